// ===== hw/rtl/brnm_pkg.sv =====
// shared types and constants of the beam range noise model
`timescale 1ns / 1ps
`default_nettype none

package brnm_pkg;

   localparam int unsigned DATA_W      = 16;
   localparam int unsigned FRAC_BITS   = 12;
   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANGE_LIMIT = 3'd0,
      CSR_PROB_RANDOM = 3'd1,
      CSR_PROB_MISS   = 3'd2,
      CSR_PROB_SHORT  = 3'd3,
      CSR_NOISE_SIGMA = 3'd4,
      CSR_INV_LAMBDA  = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      OUT_RANDOM   = 3'd0,
      OUT_MISS     = 3'd1,
      OUT_SHORT    = 3'd2,
      OUT_HIT      = 3'd3,
      OUT_HIT_CLIP = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [DATA_W-1:0] range_limit;
      logic [DATA_W-1:0] prob_random;
      logic [DATA_W-1:0] prob_miss;
      logic [DATA_W-1:0] prob_short;
      logic [DATA_W-1:0] noise_sigma;
      logic [DATA_W-1:0] inv_lambda_short;
   } cfg_type;

   // after the multipliers
   typedef struct packed {
      logic [DATA_W-1:0]   depth;
      logic                last;
      logic                sel_random;
      logic                sel_miss;
      logic                sel_short;
      logic [2*DATA_W-1:0] prod_random;
      logic [2*DATA_W-1:0] prod_short;
      logic signed [2*DATA_W:0] prod_noise;
   } s1_type;

   // after classification
   typedef struct packed {
      outcome_type       kind;
      logic              last;
      logic [DATA_W-1:0] range_random;
      logic [DATA_W-1:0] range_short;
      logic [DATA_W-1:0] range_hit;
   } s2_type;

endpackage

`default_nettype wire

// ===== hw/rtl/brnm_if.sv =====
// handshake channels of the beam range noise model
`timescale 1ns / 1ps
`default_nettype none

interface brnm_req_if;
   logic              valid;
   logic              ready;
   logic [15:0]       true_depth;
   logic [15:0]       event_draw;
   logic [15:0]       random_draw;
   logic signed [15:0] gauss_draw;
   logic [15:0]       expo_draw;
   logic              last_in;

   modport source (output valid, true_depth, event_draw, random_draw, gauss_draw,
                   expo_draw, last_in, input ready);
   modport sink   (input valid, true_depth, event_draw, random_draw, gauss_draw,
                   expo_draw, last_in, output ready);
endinterface

interface brnm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] measured_range;
   logic [2:0]  outcome;
   logic        last_out;

   modport source (output valid, measured_range, outcome, last_out, input ready);
   modport sink   (input valid, measured_range, outcome, last_out, output ready);
endinterface

interface brnm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/beam_range_noise_model_unit.sv =====
// top level of the beam range noise model
`timescale 1ns / 1ps
`default_nettype none

// Beam-model range noise: each request word carries a true depth and four
// pre-drawn variates and produces exactly one response word with the
// corrupted range, an outcome code and the scan-end flag. The datapath is a
// three-stage pipeline (multipliers and threshold compares, then the short
// test and the hit sum with its range check, then the range select into the
// output register). One word is taken per clock unless the pipe stalls.
// Each stage advances when it is empty or the stage after it advances, so
// a stalled response holds the pipe without losing or repeating a word and
// bubbles are squeezed out. Configuration is a register file with no reset
// sweep; write it only while the pipe is empty.

module beam_range_noise_model_unit
   import brnm_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   brnm_req_if.sink   req_chan,
   brnm_rsp_if.source rsp_chan,
   brnm_csr_if.sink   csr_chan
);

   cfg_type cfg;

   // stage valids and payloads
   logic   s1_valid;
   s1_type s1_data;
   logic   s2_valid;
   s2_type s2_data;

   // per-stage advance, back to front
   logic adv1;
   logic adv2;
   logic adv3;

   assign adv3 = !rsp_chan.valid || rsp_chan.ready;
   assign adv2 = !s2_valid || adv3;
   assign adv1 = !s1_valid || adv2;

   brnm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // products and compares
   brnm_draw_stage u_draw (
      .clock     (clock),
      .reset     (reset),
      .advance   (adv1),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .valid_out (s1_valid),
      .data_out  (s1_data)
   );

   // outcome decision
   brnm_classify_stage u_classify (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv2),
      .cfg        (cfg),
      .valid_in   (s1_valid),
      .data_in_s1 (s1_data),
      .valid_out  (s2_valid),
      .data_out   (s2_data)
   );

   // output register
   brnm_select_stage u_select (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv3),
      .cfg        (cfg),
      .valid_in   (s2_valid),
      .data_in_s2 (s2_data),
      .rsp_chan   (rsp_chan)
   );

   // an accepted request lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid)
      else $error("accepted word did not reach stage 1");

   // a full stage 2 behind a stalled output must hold
   a_stall_holds_s2: assert property (@(posedge clock) disable iff (reset)
      (s2_valid && rsp_chan.valid && !rsp_chan.ready) |=> s2_valid)
      else $error("stage 2 word lost during stall");

   // outcome code stays in range
   a_outcome_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.outcome <= OUT_HIT_CLIP))
      else $error("illegal outcome code");

   // miss and clipped hit report the maximum range
   a_miss_is_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.outcome == OUT_MISS || rsp_chan.outcome == OUT_HIT_CLIP))
      |-> (rsp_chan.measured_range == cfg.range_limit))
      else $error("miss or clipped hit without max range");

endmodule

`default_nettype wire

// ===== hw/rtl/brnm_csr.sv =====
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module brnm_csr
   import brnm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   brnm_csr_if.sink  csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_RANGE_LIMIT: cfg_in.range_limit      = csr_chan.data;
            CSR_PROB_RANDOM: cfg_in.prob_random      = csr_chan.data;
            CSR_PROB_MISS:   cfg_in.prob_miss        = csr_chan.data;
            CSR_PROB_SHORT:  cfg_in.prob_short       = csr_chan.data;
            CSR_NOISE_SIGMA: cfg_in.noise_sigma      = csr_chan.data;
            CSR_INV_LAMBDA:  cfg_in.inv_lambda_short = csr_chan.data;
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_limit      <= 16'hFFFF;
         cfg_ff.prob_random      <= '0;
         cfg_ff.prob_miss        <= '0;
         cfg_ff.prob_short       <= '0;
         cfg_ff.noise_sigma      <= '0;
         cfg_ff.inv_lambda_short <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/brnm_draw_stage.sv =====
// stage 1: threshold compares and the three products
`timescale 1ns / 1ps
`default_nettype none

module brnm_draw_stage
   import brnm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  cfg_type   cfg,
   brnm_req_if.sink  req_chan,
   output logic      valid_out,
   output s1_type    data_out
);

   logic              valid_ff;
   s1_type            data_ff;
   s1_type            data_in;
   logic [DATA_W+1:0] th_random;
   logic [DATA_W+1:0] th_miss;
   logic [DATA_W+1:0] th_short;
   logic [DATA_W+1:0] ev;

   assign req_chan.ready = advance;
   assign valid_out      = valid_ff;
   assign data_out       = data_ff;

   always_comb begin
      // cumulative thresholds, unwrapped
      th_random = {2'b00, cfg.prob_random};
      th_miss   = th_random + {2'b00, cfg.prob_miss};
      th_short  = th_miss + {2'b00, cfg.prob_short};
      ev        = {2'b00, req_chan.event_draw};

      data_in.depth       = req_chan.true_depth;
      data_in.last        = req_chan.last_in;
      data_in.sel_random  = (ev <= th_random);
      data_in.sel_miss    = (ev <= th_miss);
      data_in.sel_short   = (ev <= th_short);
      data_in.prod_random = (2*DATA_W)'(cfg.range_limit)
                            * (2*DATA_W)'(req_chan.random_draw);
      data_in.prod_short  = (2*DATA_W)'(cfg.inv_lambda_short)
                            * (2*DATA_W)'(req_chan.expo_draw);
      data_in.prod_noise  = (2*DATA_W+1)'($signed({1'b0, cfg.noise_sigma}))
                            * (2*DATA_W+1)'(req_chan.gauss_draw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/brnm_classify_stage.sv =====
// stage 2: short test, hit sum and range check, outcome decision
`timescale 1ns / 1ps
`default_nettype none

module brnm_classify_stage
   import brnm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  cfg_type   cfg,
   input  wire logic valid_in,
   input  s1_type    data_in_s1,
   output logic      valid_out,
   output s2_type    data_out
);

   localparam int unsigned SUM_W = 2*DATA_W + 2;

   logic                    valid_ff;
   s2_type                  data_ff;
   s2_type                  data_in;
   logic [DATA_W+3:0]       scaled_short;
   logic                    short_ok;
   logic signed [SUM_W-1:0] hit_sum;
   logic signed [SUM_W-1:0] hit_lim;
   logic                    hit_clip;

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

   always_comb begin
      scaled_short = data_in_s1.prod_short[2*DATA_W-1:FRAC_BITS];
      short_ok     = (scaled_short <= {4'b0000, data_in_s1.depth});

      // depth in q.12 plus sigma times gauss
      hit_sum  = SUM_W'($signed({1'b0, data_in_s1.depth, {FRAC_BITS{1'b0}}}))
                 + SUM_W'(data_in_s1.prod_noise);
      hit_lim  = SUM_W'($signed({1'b0, cfg.range_limit, {FRAC_BITS{1'b0}}}));
      hit_clip = hit_sum[SUM_W-1] || (hit_sum > hit_lim);

      if (data_in_s1.sel_random) begin
         data_in.kind = OUT_RANDOM;
      end else if (data_in_s1.sel_miss) begin
         data_in.kind = OUT_MISS;
      end else if (data_in_s1.sel_short && short_ok) begin
         data_in.kind = OUT_SHORT;
      end else if (hit_clip) begin
         data_in.kind = OUT_HIT_CLIP;
      end else begin
         data_in.kind = OUT_HIT;
      end

      data_in.last         = data_in_s1.last;
      data_in.range_random = data_in_s1.prod_random[2*DATA_W-1:DATA_W];
      data_in.range_short  = scaled_short[DATA_W-1:0];
      data_in.range_hit    = hit_sum[DATA_W+FRAC_BITS-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/brnm_select_stage.sv =====
// stage 3: range select into the output register
`timescale 1ns / 1ps
`default_nettype none

module brnm_select_stage
   import brnm_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  advance,
   input  cfg_type    cfg,
   input  wire logic  valid_in,
   input  s2_type     data_in_s2,
   brnm_rsp_if.source rsp_chan
);

   logic              valid_ff;
   logic [DATA_W-1:0] range_ff;
   logic [DATA_W-1:0] range_in;
   outcome_type       kind_ff;
   logic              last_ff;

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.measured_range = range_ff;
   assign rsp_chan.outcome        = kind_ff;
   assign rsp_chan.last_out       = last_ff;

   always_comb begin
      case (data_in_s2.kind)
         OUT_RANDOM: range_in = data_in_s2.range_random;
         OUT_SHORT:  range_in = data_in_s2.range_short;
         OUT_HIT:    range_in = data_in_s2.range_hit;
         default:    range_in = cfg.range_limit;  // miss and clipped hit
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         range_ff <= range_in;
         kind_ff  <= data_in_s2.kind;
         last_ff  <= data_in_s2.last;
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_beam_range_noise_model_unit.sv =====
// self-checking testbench of the beam range noise model unit
`timescale 1ns / 1ps

module tb_beam_range_noise_model_unit;
   import brnm_pkg::*;

   localparam int unsigned RANDOM_PHASES   = 12;
   localparam int unsigned ITEMS_PER_PHASE = 157;
   localparam int unsigned HOLD_CYCLES     = 200;  // long receiver hold-off
   localparam int unsigned SETTLE_CYCLES   = 8;    // pipe is three deep
   localparam int unsigned LIMIT_NS        = 4_000_000;

   // register indexes the block has no register behind
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   // one sensor reading with its pre-drawn variates
   typedef struct packed {
      logic [15:0]        depth;
      logic [15:0]        ev;
      logic [15:0]        rnd;
      logic signed [15:0] gauss;
      logic [15:0]        expo;
      logic               last;
   } reading_type;

   // one range word as the block should return it
   typedef struct packed {
      logic [15:0] measured;
      outcome_type kind;
      logic        last;
   } range_word_type;

   // directed row: typed rows carry their answer, the rest go through the predictor
   typedef struct packed {
      reading_type    rd;
      bit             typed;
      range_word_type word;
   } sweep_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   brnm_req_if req_if();
   brnm_rsp_if rsp_if();
   brnm_csr_if csr_if();

   beam_range_noise_model_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #2 clock = ~clock;

   cfg_type        sensor_cfg;       // shadow copy of the register file
   range_word_type pending_ranges[$];
   int unsigned    mismatch_count = 0;
   bit             sender_calm    = 1'b0;
   bit             receiver_calm  = 1'b0;
   bit             squeeze_pending = 1'b0;

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatch_count++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // beam model: event variate against cumulative thresholds, then the
   // selected return; thresholds are kept 18 bits wide so they never wrap
   function automatic range_word_type corrupt_range(input cfg_type c,
                                                    input reading_type r);
      range_word_type w;
      logic [17:0]    th_random, th_miss, th_short;
      logic [31:0]    prod;
      logic [19:0]    scaled_short;
      longint         s, lim;
      th_random    = {2'b00, c.prob_random};
      th_miss      = th_random + c.prob_miss;
      th_short     = th_miss + c.prob_short;
      prod         = r.expo * c.inv_lambda_short;
      scaled_short = prod[31:FRAC_BITS];
      w.last       = r.last;
      if (r.ev <= th_random) begin
         prod       = c.range_limit * r.rnd;
         w.measured = prod[31:16];
         w.kind     = OUT_RANDOM;
      end else if (r.ev <= th_miss) begin
         w.measured = c.range_limit;
         w.kind     = OUT_MISS;
      end else if (r.ev <= th_short && scaled_short <= r.depth) begin
         w.measured = scaled_short[15:0];
         w.kind     = OUT_SHORT;
      end else begin
         // short beyond the depth lands here too and is treated as a hit
         s   = (longint'(r.depth) <<< FRAC_BITS)
               + longint'(c.noise_sigma) * longint'($signed(r.gauss));
         lim = longint'(c.range_limit) <<< FRAC_BITS;
         if (s < 0 || s > lim) begin
            w.measured = c.range_limit;
            w.kind     = OUT_HIT_CLIP;
         end else begin
            w.measured = 16'(s >>> FRAC_BITS);
            w.kind     = OUT_HIT;
         end
      end
      return w;
   endfunction

   function automatic sweep_row_type make_row(
      input logic [15:0] depth, input logic [15:0] ev, input logic [15:0] rnd,
      input logic [15:0] gauss, input logic [15:0] expo, input logic last,
      input bit typed, input logic [15:0] measured, input outcome_type kind);
      sweep_row_type row;
      row.rd.depth      = depth;
      row.rd.ev         = ev;
      row.rd.rnd        = rnd;
      row.rd.gauss      = gauss;
      row.rd.expo       = expo;
      row.rd.last       = last;
      row.typed         = typed;
      row.word.measured = measured;
      row.word.kind     = kind;
      row.word.last     = last;
      return row;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // register value: sometimes an extreme, else within a useful span
   function automatic logic [15:0] pick_setting(input int unsigned typical_hi);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom_range(0, typical_hi));
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.range_limit      = pick_setting(16'hFFFF);
      c.prob_random      = pick_setting(16'h5000);
      c.prob_miss        = pick_setting(16'h5000);
      c.prob_short       = pick_setting(16'h5000);
      c.noise_sigma      = pick_setting(16'h0800);
      c.inv_lambda_short = pick_setting(16'h4000);
      return c;
   endfunction

   // random reading biased toward depths inside the range and modest variates
   function automatic reading_type draw_reading();
      reading_type r;
      if ($urandom_range(0, 3) != 0)
         r.depth = 16'($urandom_range(0, sensor_cfg.range_limit));
      else
         r.depth = 16'($urandom);
      r.ev  = 16'($urandom);
      r.rnd = 16'($urandom);
      if ($urandom_range(0, 9) < 7)
         r.gauss = 16'(int'($urandom_range(0, 16383)) - 8192);
      else
         r.gauss = 16'($urandom);
      if ($urandom_range(0, 9) < 6)
         r.expo = 16'($urandom_range(0, 16'h3000));
      else
         r.expo = 16'($urandom);
      r.last = 1'($urandom);
      return r;
   endfunction

   // one register write; valid stays up so back-to-back writes need no bubble
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         CSR_RANGE_LIMIT: sensor_cfg.range_limit      = value;
         CSR_PROB_RANDOM: sensor_cfg.prob_random      = value;
         CSR_PROB_MISS:   sensor_cfg.prob_miss        = value;
         CSR_PROB_SHORT:  sensor_cfg.prob_short       = value;
         CSR_NOISE_SIGMA: sensor_cfg.noise_sigma      = value;
         CSR_INV_LAMBDA:  sensor_cfg.inv_lambda_short = value;
         default: ;  // unmapped index, the block drops it
      endcase
   endtask

   task automatic load_settings(input cfg_type c, input bit poke_unmapped);
      write_register(CSR_RANGE_LIMIT, c.range_limit);
      if (poke_unmapped)
         write_register($urandom_range(0, 1) ? CSR_UNMAPPED_LOW : CSR_UNMAPPED_HIGH,
                        16'($urandom));
      write_register(CSR_PROB_RANDOM, c.prob_random);
      write_register(CSR_PROB_MISS, c.prob_miss);
      write_register(CSR_PROB_SHORT, c.prob_short);
      write_register(CSR_NOISE_SIGMA, c.noise_sigma);
      write_register(CSR_INV_LAMBDA, c.inv_lambda_short);
      csr_if.valid <= 1'b0;
   endtask

   // offer one reading, then record its expected range word once accepted
   task automatic send_reading(input reading_type r, input bit typed,
                               input range_word_type typed_word);
      int unsigned idle;
      idle = sender_calm ? 0 : pick_gap();
      if (idle != 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.true_depth  <= r.depth;
      req_if.event_draw  <= r.ev;
      req_if.random_draw <= r.rnd;
      req_if.gauss_draw  <= r.gauss;
      req_if.expo_draw   <= r.expo;
      req_if.last_in     <= r.last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_ranges.push_back(typed ? typed_word : corrupt_range(sensor_cfg, r));
   endtask

   task automatic run_rows(input sweep_row_type rows[$]);
      foreach (rows[i]) send_reading(rows[i].rd, rows[i].typed, rows[i].word);
   endtask

   // drop valid and wait until every expected range word has come back
   task automatic drain_pipe();
      req_if.valid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
   endtask

   // response side ready, with random stalls and one long hold-off on request
   initial begin
      int unsigned idle;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_pending) begin
            squeeze_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            idle = receiver_calm ? 0 : pick_gap();
            if (idle != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (idle) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // range word checker, sampled at the edge that accepts the word
   always @(posedge clock) begin
      range_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_ranges.size() == 0) begin
            flag_mismatch("range word with no reading pending",
                          rsp_if.measured_range, 0);
         end else begin
            want = pending_ranges.pop_front();
            if (rsp_if.measured_range !== want.measured)
               flag_mismatch("measured_range", rsp_if.measured_range, want.measured);
            if (rsp_if.outcome !== want.kind)
               flag_mismatch("outcome", rsp_if.outcome, want.kind);
            if (rsp_if.last_out !== want.last)
               flag_mismatch("last_out", rsp_if.last_out, want.last);
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("tb_beam_range_noise_model_unit NOT OK");
      $finish;
   end

   initial begin
      sweep_row_type reset_rows[$];
      sweep_row_type directed_rows[$];
      cfg_type       fixed_cfg;

      req_if.valid       <= 1'b0;
      req_if.true_depth  <= '0;
      req_if.event_draw  <= '0;
      req_if.random_draw <= '0;
      req_if.gauss_draw  <= '0;
      req_if.expo_draw   <= '0;
      req_if.last_in     <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= '0;
      csr_if.data        <= '0;

      // register values right after reset
      sensor_cfg.range_limit      = 16'hFFFF;
      sensor_cfg.prob_random      = 16'h0000;
      sensor_cfg.prob_miss        = 16'h0000;
      sensor_cfg.prob_short       = 16'h0000;
      sensor_cfg.noise_sigma      = 16'h0000;
      sensor_cfg.inv_lambda_short = 16'h0001;

      // reset settings: zero probabilities leave only event 0 as random,
      // zero sigma makes every hit return the depth itself
      //                             depth     ev        rnd       gauss     expo      last
      reset_rows.push_back(make_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                    1'b1, 16'd0, OUT_RANDOM));
      reset_rows.push_back(make_row(16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1,
                                    1'b0, 16'd0, OUT_RANDOM));
      reset_rows.push_back(make_row(16'hFFFF, 16'h0001, 16'h0000, 16'h7FFF, 16'h0000, 1'b0,
                                    1'b1, 16'hFFFF, OUT_HIT));
      reset_rows.push_back(make_row(16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 1'b1,
                                    1'b1, 16'd0, OUT_HIT));

      // directed settings: range 1000, thresholds at 1/16 steps, sigma 100,
      // unit reciprocal so a short return equals the exponential draw
      fixed_cfg.range_limit      = 16'd1000;
      fixed_cfg.prob_random      = 16'h1000;
      fixed_cfg.prob_miss        = 16'h1000;
      fixed_cfg.prob_short       = 16'h1000;
      fixed_cfg.noise_sigma      = 16'd100;
      fixed_cfg.inv_lambda_short = 16'h1000;

      // random return at both ends of its variate
      directed_rows.push_back(make_row(16'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                       1'b1, 16'd0, OUT_RANDOM));
      directed_rows.push_back(make_row(16'd700, 16'h1000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0,
                                       1'b0, 16'd0, OUT_RANDOM));
      // miss just past and right at its threshold
      directed_rows.push_back(make_row(16'd700, 16'h1001, 16'h8000, 16'h0000, 16'h0000, 1'b0,
                                       1'b1, 16'd1000, OUT_MISS));
      directed_rows.push_back(make_row(16'd700, 16'h2000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                       1'b1, 16'd1000, OUT_MISS));
      // short below and equal to the depth
      directed_rows.push_back(make_row(16'd600, 16'h2001, 16'h0000, 16'h0000, 16'd500, 1'b0,
                                       1'b0, 16'd0, OUT_SHORT));
      directed_rows.push_back(make_row(16'd600, 16'h3000, 16'h0000, 16'h0000, 16'd600, 1'b0,
                                       1'b0, 16'd0, OUT_SHORT));
      // short beyond the depth falls back to a hit
      directed_rows.push_back(make_row(16'd600, 16'h3000, 16'h0000, 16'h0000, 16'd601, 1'b0,
                                       1'b1, 16'd600, OUT_HIT));
      directed_rows.push_back(make_row(16'd100, 16'h2800, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b1,
                                       1'b0, 16'd0, OUT_HIT));
      // short at full scale is not bounded by the range
      directed_rows.push_back(make_row(16'hFFFF, 16'h2001, 16'h0000, 16'h0000, 16'hFFFF, 1'b0,
                                       1'b0, 16'd0, OUT_SHORT));
      // hit noise pushing below zero
      directed_rows.push_back(make_row(16'd0, 16'h3001, 16'h0000, 16'hFFFF, 16'h0000, 1'b0,
                                       1'b1, 16'd1000, OUT_HIT_CLIP));
      directed_rows.push_back(make_row(16'd500, 16'h9000, 16'h0000, 16'h8000, 16'h0000, 1'b1,
                                       1'b1, 16'd1000, OUT_HIT_CLIP));
      // hit exactly at the range is kept, any fraction past it is clipped
      directed_rows.push_back(make_row(16'd1000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                       1'b1, 16'd1000, OUT_HIT));
      directed_rows.push_back(make_row(16'd1000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000, 1'b0,
                                       1'b1, 16'd1000, OUT_HIT_CLIP));
      directed_rows.push_back(make_row(16'd999, 16'h8000, 16'h0000, 16'd40, 16'h0000, 1'b1,
                                       1'b0, 16'd0, OUT_HIT));
      directed_rows.push_back(make_row(16'hFFFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                       1'b1, 16'd1000, OUT_HIT_CLIP));
      directed_rows.push_back(make_row(16'd0, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                       1'b1, 16'd0, OUT_HIT));
      // gaussian at its largest and at plus one sigma
      directed_rows.push_back(make_row(16'd500, 16'h9000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0,
                                       1'b0, 16'd0, OUT_HIT));
      directed_rows.push_back(make_row(16'd123, 16'h7777, 16'h0000, 16'h1000, 16'h0000, 1'b0,
                                       1'b0, 16'd0, OUT_HIT));
      // alternating bit patterns on the depth, event, random and exponential fields
      directed_rows.push_back(make_row(16'hAAAA, 16'h5555, 16'h5555, 16'hF000, 16'hAAAA, 1'b1,
                                       1'b0, 16'd0, OUT_HIT));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_rows(reset_rows);
      drain_pipe();
      load_settings(fixed_cfg, 1'b1);
      run_rows(directed_rows);
      drain_pipe();

      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               // probabilities summing past one: short and hit unreachable
               fixed_cfg.range_limit      = 16'hFFFF;
               fixed_cfg.prob_random      = 16'h8000;
               fixed_cfg.prob_miss        = 16'h8000;
               fixed_cfg.prob_short       = 16'hFFFF;
               fixed_cfg.noise_sigma      = 16'hFFFF;
               fixed_cfg.inv_lambda_short = 16'hFFFF;
            end
            1: fixed_cfg = '0;  // zero range, zero sigma, zero reciprocal
            default: fixed_cfg = random_settings();
         endcase
         sender_calm   = (p % 5 == 3) || (p == 5);
         receiver_calm = (p % 5 == 4);
         load_settings(fixed_cfg, $urandom_range(0, 1));
         // long receiver hold-off while the sender keeps offering words
         if (p == 5) squeeze_pending = 1'b1;
         repeat (ITEMS_PER_PHASE) send_reading(draw_reading(), 1'b0, '0);
         drain_pipe();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_ranges.size() != 0)
         flag_mismatch("range words never returned", pending_ranges.size(), 0);
      if (mismatch_count == 0)
         $display("tb_beam_range_noise_model_unit OK");
      else
         $display("tb_beam_range_noise_model_unit NOT OK");
      $finish;
   end

endmodule
